>>> rtl/l4_flow_load_balancer_top_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef L4_FLOW_LOAD_BALANCER_TOP_MACROS_SVH
`define L4_FLOW_LOAD_BALANCER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LB_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LB_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define LB_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

>>> rtl/l4lb_pkg.sv
`default_nettype none
package l4lb_pkg;
    localparam int FLOW_ENTRIES = 64;
    localparam int NUM_BACKENDS = 25;
    localparam int FIRST_BACKEND = 10;
    localparam int IDX_W = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);
    localparam int KEY_W = 96;
    localparam int ENT_W = KEY_W + 8;
    localparam int BK_W = $clog2(NUM_BACKENDS + 1);

    localparam logic [1:0] ACT_ABORT = 2'd0;
    localparam logic [1:0] ACT_PASS = 2'd1;
    localparam logic [1:0] ACT_XMIT = 2'd2;

    localparam logic [2:0] REG_SUBNET = 3'd0;
    localparam logic [2:0] REG_CLIENT = 3'd1;
    localparam logic [2:0] REG_BALANCER = 3'd2;
    localparam logic [2:0] REG_BMAC = 3'd3;
    localparam logic [2:0] REG_DEFAULT = 3'd4;
    localparam logic [2:0] REG_MASK = 3'd5;
    localparam logic [2:0] REG_PORT = 3'd6;

    // Status handed from the backend picker to the sequencer.
    typedef struct packed {
        logic done;
        logic any;
        logic [7:0] host;
    } pick_status_t;
endpackage
`default_nettype wire

>>> rtl/l4lb_ram.sv
`default_nettype none
module l4lb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/l4lb_picker.sv
`default_nettype none
module l4lb_picker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic [31:0] rnd,
    input wire logic [24:0] mask,
    output l4lb_pkg::pick_status_t status
);
    import l4lb_pkg::*;

    typedef enum logic [2:0] {P_IDLE, P_COUNT, P_MOD, P_SCAN, P_DONE} pstate_t;

    pstate_t state_reg, state_next;
    logic [4:0] k_reg, k_next;
    logic [BK_W-1:0] cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [5:0] bit_reg, bit_next;
    logic [31:0] q_reg, q_next;
    logic [7:0] host_reg, host_next;
    logic [32:0] trial;
    logic mbit;

    assign mbit = (k_reg < 5'(NUM_BACKENDS)) ? mask[k_reg] : 1'b0;
    assign trial = {rem_reg, q_reg[31]} - {{(33-BK_W){1'b0}}, cnt_reg};

    assign status.done = (state_reg == P_DONE);
    assign status.any = (cnt_reg != '0);
    assign status.host = host_reg;

    // Count backends, restoring divide one bit a cycle, then scan for the pick.
    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        bit_next = bit_reg;
        q_next = q_reg;
        host_next = host_reg;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    state_next = P_COUNT;
                    k_next = '0;
                    cnt_next = '0;
                    q_next = rnd;
                end
            end
            P_COUNT:
            begin
                cnt_next = cnt_reg + BK_W'(mbit);
                k_next = k_reg + 5'd1;
                if (k_reg == 5'(NUM_BACKENDS - 1))
                begin
                    state_next = P_MOD;
                    rem_next = '0;
                    bit_next = '0;
                end
            end
            P_MOD:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = P_DONE;
                end
                else
                begin
                    if (!trial[32])
                    begin
                        rem_next = trial[31:0];
                    end
                    else
                    begin
                        rem_next = {rem_reg[30:0], q_reg[31]};
                    end
                    q_next = {q_reg[30:0], 1'b0};
                    bit_next = bit_reg + 6'd1;
                    if (bit_reg == 6'd31)
                    begin
                        state_next = P_SCAN;
                        k_next = '0;
                    end
                end
            end
            P_SCAN:
            begin
                k_next = k_reg + 5'd1;
                if (mbit)
                begin
                    if (rem_reg == '0)
                    begin
                        host_next = 8'(FIRST_BACKEND) + {3'b0, k_reg};
                        state_next = P_DONE;
                    end
                    rem_next = rem_reg - 32'd1;
                end
            end
            P_DONE:
            begin
                state_next = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            k_reg <= '0;
            cnt_reg <= '0;
            rem_reg <= '0;
            bit_reg <= '0;
            q_reg <= '0;
            host_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            rem_reg <= rem_next;
            bit_reg <= bit_next;
            q_reg <= q_next;
            host_reg <= host_next;
        end
    end
endmodule
`default_nettype wire

>>> rtl/l4_flow_load_balancer_top.sv
// Result path: an aborted or passed request goes from classification straight to
// out_valid; a server reply first runs the eight-step checksum sum and its folds,
// and a client frame also examines flow table entries (up to 64) before them; a new
// client flow adds the backend count and, if any are set, the 32-step modulo and scan.
// Throughput: one frame at a time; no request is taken until the result is accepted.
// Reset clears valid bits, counters and registers to defaults; the table memory is not.
`default_nettype none
`include "l4_flow_load_balancer_top_macros.svh"
module l4_flow_load_balancer_top (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_valid,
    output logic cfg_ready,
    input wire logic [2:0] cfg_index,
    input wire logic [31:0] cfg_data,
    input wire logic in_valid,
    output logic in_ready,
    input wire logic [10:0] captured_bytes,
    input wire logic [15:0] ether_type,
    input wire logic [7:0] ip_protocol,
    input wire logic [31:0] source_addr,
    input wire logic [31:0] dest_addr,
    input wire logic [15:0] source_port,
    input wire logic [15:0] dest_port,
    input wire logic [15:0] old_checksum,
    input wire logic [31:0] random_value,
    output logic out_valid,
    input wire logic out_ready,
    output logic [1:0] action,
    output logic [31:0] new_source_addr,
    output logic [31:0] new_dest_addr,
    output logic [7:0] new_dest_mac_last,
    output logic [7:0] new_source_mac_last,
    output logic [15:0] new_checksum,
    output logic flow_created,
    output logic table_full,
    output logic [63:0] new_flow_total,
    output logic [63:0] forwarded_total
);
    import l4lb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_RD, S_CMP, S_PICK, S_WAITPK, S_INS, S_CS1, S_CS2, S_CS3, S_OUT
    } state_t;

    state_t state_reg;
    logic [23:0] subnet_reg;
    logic [7:0] client_reg, bal_reg, bmac_reg, dflt_reg;
    logic [24:0] mask_reg;
    logic [15:0] sport_cfg_reg;

    logic [KEY_W-1:0] key_reg;
    logic [15:0] hc_reg;
    logic [31:0] rnd_reg;
    logic [10:0] cap_reg;
    logic [15:0] etype_reg;
    logic [7:0] proto_reg;
    logic [FLOW_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [7:0] host_reg;
    logic [19:0] sum_reg;
    logic [2:0] term_reg;
    logic [63:0] ncc_reg, fwd_reg;
    logic pick_start_reg;
    logic ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr, free_idx;
    logic [ENT_W-1:0] ram_rdata;
    logic free_any;
    pick_status_t pk;
    logic [31:0] src_a, dst_a, nsrc_a, ndst_a, client_a;
    logic [15:0] term;

    assign client_a = {subnet_reg, client_reg};
    assign nsrc_a = {subnet_reg, bal_reg};
    assign ndst_a = {subnet_reg, host_reg};
    assign src_a = key_reg[95:64];
    assign dst_a = key_reg[63:32];
    assign cfg_ready = (state_reg == S_IDLE);
    // A configuration write takes priority over a frame in the idle state.
    assign in_ready = (state_reg == S_IDLE) && !cfg_valid;
    assign out_valid = (state_reg == S_OUT);
    assign ram_raddr = idx_reg;

    // Lowest free slot: priority pick over the valid bits.
    always_comb
    begin
        free_idx = '0;
        free_any = 1'b0;
        for (int i = FLOW_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
                free_any = 1'b1;
            end
        end
    end

    assign ram_we = (state_reg == S_INS) && free_any;
    assign ram_waddr = free_idx;

    l4lb_ram #(.WIDTH(ENT_W), .DEPTH(FLOW_ENTRIES)) u_table (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata({key_reg, host_reg}),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    l4lb_picker u_pick (
        .clk(clk),
        .rst_n(rst_n),
        .start(pick_start_reg),
        .rnd(rnd_reg),
        .mask(mask_reg),
        .status(pk)
    );

    // Checksum terms, selected in turn by term_reg, for the 20-bit accumulating adder.
    always_comb
    begin
        case (term_reg)
            3'd0: term = ~hc_reg;
            3'd1: term = ~src_a[31:16];
            3'd2: term = ~src_a[15:0];
            3'd3: term = ~dst_a[31:16];
            3'd4: term = ~dst_a[15:0];
            3'd5: term = nsrc_a[31:16];
            3'd6: term = nsrc_a[15:0];
            default: term = ndst_a[31:16];
        endcase
    end

    // Sequencer with registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            subnet_reg <= 24'd11276544;
            client_reg <= 8'd6;
            bal_reg <= 8'd7;
            bmac_reg <= 8'd2;
            dflt_reg <= 8'd10;
            mask_reg <= '0;
            sport_cfg_reg <= 16'd80;
            valid_reg <= '0;
            ncc_reg <= '0;
            fwd_reg <= '0;
            pick_start_reg <= 1'b0;
            action <= ACT_PASS;
            idx_reg <= '0;
            term_reg <= '0;
            sum_reg <= '0;
            flow_created <= 1'b0;
            table_full <= 1'b0;
            key_reg <= '0;
            hc_reg <= '0;
            rnd_reg <= '0;
            cap_reg <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            host_reg <= '0;
            new_source_addr <= '0;
            new_dest_addr <= '0;
            new_dest_mac_last <= '0;
            new_source_mac_last <= '0;
            new_checksum <= '0;
        end
        else
        begin
            pick_start_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_SUBNET: subnet_reg <= cfg_data[23:0];
                            REG_CLIENT: client_reg <= cfg_data[7:0];
                            REG_BALANCER: bal_reg <= cfg_data[7:0];
                            REG_BMAC: bmac_reg <= cfg_data[7:0];
                            REG_DEFAULT: dflt_reg <= cfg_data[7:0];
                            REG_MASK: mask_reg <= cfg_data[24:0];
                            REG_PORT: sport_cfg_reg <= cfg_data[15:0];
                            default: ;
                        endcase
                    end
                    else if (in_valid)
                    begin
                        key_reg <= {source_addr, dest_addr, source_port, dest_port};
                        hc_reg <= old_checksum;
                        rnd_reg <= random_value;
                        cap_reg <= captured_bytes;
                        etype_reg <= ether_type;
                        proto_reg <= ip_protocol;
                        state_reg <= S_CLASS;
                    end
                end
                S_CLASS:
                begin
                    flow_created <= 1'b0;
                    table_full <= 1'b0;
                    new_source_addr <= '0;
                    new_dest_addr <= '0;
                    new_dest_mac_last <= '0;
                    new_source_mac_last <= '0;
                    new_checksum <= '0;
                    sum_reg <= '0;
                    term_reg <= '0;
                    idx_reg <= '0;
                    host_reg <= dflt_reg;
                    state_reg <= S_OUT;
                    if (cap_reg < 11'd14)
                    begin
                        action <= ACT_ABORT;
                    end
                    else if (etype_reg != 16'h0800)
                    begin
                        action <= ACT_PASS;
                    end
                    else if (cap_reg < 11'd34)
                    begin
                        action <= ACT_ABORT;
                    end
                    else if (proto_reg != 8'd6 || cap_reg < 11'd54)
                    begin
                        action <= ACT_PASS;
                    end
                    else if (src_a == client_a)
                    begin
                        action <= ACT_XMIT;
                        state_reg <= S_RD;
                    end
                    else if (key_reg[31:16] == sport_cfg_reg)
                    begin
                        action <= ACT_XMIT;
                        host_reg <= client_reg;
                        state_reg <= S_CS1;
                    end
                    else
                    begin
                        action <= ACT_PASS;
                    end
                end
                S_RD:
                begin
                    // Read address is applied; data arrives next cycle.
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (valid_reg[idx_reg] && ram_rdata[ENT_W-1:8] == key_reg)
                    begin
                        host_reg <= ram_rdata[7:0];
                        state_reg <= S_CS1;
                    end
                    else if (idx_reg == IDX_W'(FLOW_ENTRIES - 1))
                    begin
                        ncc_reg <= ncc_reg + 64'd1;
                        pick_start_reg <= 1'b1;
                        state_reg <= S_PICK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_PICK:
                begin
                    state_reg <= S_WAITPK;
                end
                S_WAITPK:
                begin
                    if (pk.done)
                    begin
                        if (pk.any)
                        begin
                            host_reg <= pk.host;
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            state_reg <= S_CS1;
                        end
                    end
                end
                S_INS:
                begin
                    if (free_any)
                    begin
                        valid_reg[free_idx] <= 1'b1;
                        flow_created <= 1'b1;
                    end
                    else
                    begin
                        table_full <= 1'b1;
                    end
                    state_reg <= S_CS1;
                end
                S_CS1:
                begin
                    // Accumulate terms 0..7 one per cycle, then the last one.
                    sum_reg <= sum_reg + {4'd0, term};
                    term_reg <= term_reg + 3'd1;
                    if (term_reg == 3'd7)
                    begin
                        state_reg <= S_CS2;
                    end
                end
                S_CS2:
                begin
                    sum_reg <= {4'd0, sum_reg[15:0]} + {16'd0, sum_reg[19:16]}
                        + {4'd0, ndst_a[15:0]};
                    state_reg <= S_CS3;
                end
                S_CS3:
                begin
                    if (sum_reg[19:16] != 4'd0)
                    begin
                        sum_reg <= {4'd0, sum_reg[15:0]} + {16'd0, sum_reg[19:16]};
                    end
                    else
                    begin
                        new_checksum <= ~sum_reg[15:0];
                        new_source_addr <= nsrc_a;
                        new_dest_addr <= ndst_a;
                        new_source_mac_last <= bal_reg;
                        if (src_a == client_a)
                        begin
                            new_dest_mac_last <= bmac_reg;
                            fwd_reg <= fwd_reg + 64'd1;
                        end
                        else
                        begin
                            new_dest_mac_last <= client_reg;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign new_flow_total = ncc_reg;
    assign forwarded_total = fwd_reg;

    `LB_ASSERT_IMP(a_out_no_in, clk, rst_n, out_valid, !in_ready)
    `LB_ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(flow_created && table_full))
    `LB_ASSERT_IMP(a_xmit_flags, clk, rst_n, out_valid && action != ACT_XMIT,
        !flow_created && !table_full)
    `LB_ASSERT_NEXT(a_ins_full, clk, rst_n, state_reg == S_INS && !free_any, table_full)
endmodule
`default_nettype wire

>>> bench/lb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module lb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_valid,
    input wire logic cfg_ready,
    input wire logic [2:0] cfg_index,
    input wire logic [31:0] cfg_data,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic [10:0] captured_bytes,
    input wire logic [15:0] ether_type,
    input wire logic [7:0] ip_protocol,
    input wire logic [31:0] source_addr,
    input wire logic [31:0] dest_addr,
    input wire logic [15:0] source_port,
    input wire logic [15:0] dest_port,
    input wire logic [15:0] old_checksum,
    input wire logic [31:0] random_value,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [1:0] action,
    input wire logic [31:0] new_source_addr,
    input wire logic [31:0] new_dest_addr,
    input wire logic [7:0] new_dest_mac_last,
    input wire logic [7:0] new_source_mac_last,
    input wire logic [15:0] new_checksum,
    input wire logic flow_created,
    input wire logic table_full,
    input wire logic [63:0] new_flow_total,
    input wire logic [63:0] forwarded_total,
    output int errors,
    output int pending
);
    import l4lb_pkg::*;

    typedef struct packed {
        logic [1:0] act;
        logic [31:0] nsrc;
        logic [31:0] ndst;
        logic [7:0] dmac;
        logic [7:0] smac;
        logic [15:0] csum;
        logic created;
        logic full;
        logic [63:0] newcnt;
        logic [63:0] fwdcnt;
    } verdict_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0] host;
    } flow_t;

    verdict_t verdicts_due[$];
    flow_t flows[FLOW_ENTRIES];
    logic flow_used[FLOW_ENTRIES];
    logic [63:0] new_conns, fwd_frames;
    logic [23:0] r_prefix;
    logic [7:0] r_client, r_bal, r_bmac, r_default;
    logic [24:0] r_mask;
    logic [15:0] r_port;

    assign pending = verdicts_due.size();

    function automatic logic [31:0] host_ip(input logic [7:0] h);
        return {r_prefix, h};
    endfunction

    // Complement of the one's complement sum of sixteen-bit words with end-around carry.
    function automatic logic [15:0] rewrite_csum(input logic [15:0] hc, input logic [31:0] os,
        input logic [31:0] od, input logic [31:0] ns, input logic [31:0] nd);
        logic [31:0] s;
        s = {16'd0, ~hc} + {16'd0, ~os[31:16]} + {16'd0, ~os[15:0]} + {16'd0, ~od[31:16]}
            + {16'd0, ~od[15:0]} + ns[31:16] + ns[15:0] + nd[31:16] + nd[15:0];
        while (s > 32'hFFFF)
            s = (s & 32'hFFFF) + (s >> 16);
        return ~s[15:0];
    endfunction

    // Work out the verdict of one accepted request and update the flow table.
    task automatic balance_frame();
        verdict_t v;
        logic [7:0] host;
        logic found;
        int cnt, pick, seen;
        v = '0;
        v.act = ACT_PASS;
        if (captured_bytes < 14) v.act = ACT_ABORT;
        else if (ether_type != 16'h0800) v.act = ACT_PASS;
        else if (captured_bytes < 34) v.act = ACT_ABORT;
        else if (ip_protocol != 8'd6) v.act = ACT_PASS;
        else if (captured_bytes < 54) v.act = ACT_PASS;
        else if (source_addr == host_ip(r_client)) begin
            host = r_default;
            found = 0;
            for (int i = 0; i < FLOW_ENTRIES; i++)
                if (!found && flow_used[i] && flows[i].src == source_addr
                    && flows[i].dst == dest_addr && flows[i].sport == source_port
                    && flows[i].dport == dest_port)
                begin
                    host = flows[i].host;
                    found = 1;
                end
            if (!found) begin
                new_conns++;
                cnt = 0;
                for (int k = 0; k < NUM_BACKENDS; k++)
                    if (r_mask[k]) cnt++;
                if (cnt > 0) begin
                    pick = random_value % cnt;
                    seen = 0;
                    for (int k = 0; k < NUM_BACKENDS; k++)
                        if (r_mask[k]) begin
                            if (seen == pick) host = 8'(FIRST_BACKEND + k);
                            seen++;
                        end
                    v.full = 1;
                    for (int i = 0; i < FLOW_ENTRIES; i++)
                        if (v.full && !flow_used[i]) begin
                            flow_used[i] = 1;
                            flows[i] = '{source_addr, dest_addr, source_port, dest_port, host};
                            v.created = 1;
                            v.full = 0;
                        end
                end
            end
            v.act = ACT_XMIT;
            v.ndst = host_ip(host);
            v.nsrc = host_ip(r_bal);
            v.dmac = r_bmac;
            v.smac = r_bal;
            v.csum = rewrite_csum(old_checksum, source_addr, dest_addr, v.nsrc, v.ndst);
            fwd_frames++;
        end else if (source_port == r_port) begin
            v.act = ACT_XMIT;
            v.ndst = host_ip(r_client);
            v.nsrc = host_ip(r_bal);
            v.dmac = r_client;
            v.smac = r_bal;
            v.csum = rewrite_csum(old_checksum, source_addr, dest_addr, v.nsrc, v.ndst);
        end
        v.newcnt = new_conns;
        v.fwdcnt = fwd_frames;
        verdicts_due.push_back(v);
    endtask

    // Compare one accepted result with the oldest verdict.
    task automatic compare_result();
        verdict_t want, got;
        got = '{action, new_source_addr, new_dest_addr, new_dest_mac_last,
                new_source_mac_last, new_checksum, flow_created, table_full,
                new_flow_total, forwarded_total};
        if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
        end else begin
            want = verdicts_due.pop_front();
            if (want.act != got.act || want.nsrc != got.nsrc || want.ndst != got.ndst
                || want.dmac != got.dmac || want.smac != got.smac || want.csum != got.csum
                || want.created != got.created || want.full != got.full
                || want.newcnt != got.newcnt || want.fwdcnt != got.fwdcnt)
            begin
                $display("%0t: result differs: expected %h actual %h", $time, want, got);
                errors++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            errors = 0;
            verdicts_due.delete();
            for (int i = 0; i < FLOW_ENTRIES; i++) flow_used[i] = 0;
            new_conns = 0;
            fwd_frames = 0;
            r_prefix = 24'd11276544;
            r_client = 8'd6;
            r_bal = 8'd7;
            r_bmac = 8'd2;
            r_default = 8'd10;
            r_mask = '0;
            r_port = 16'd80;
        end else begin
            if (out_valid && out_ready) compare_result();
            if (in_valid && in_ready) balance_frame();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SUBNET: r_prefix = cfg_data[23:0];
                    REG_CLIENT: r_client = cfg_data[7:0];
                    REG_BALANCER: r_bal = cfg_data[7:0];
                    REG_BMAC: r_bmac = cfg_data[7:0];
                    REG_DEFAULT: r_default = cfg_data[7:0];
                    REG_MASK: r_mask = cfg_data[24:0];
                    REG_PORT: r_port = cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

>>> bench/tb_l4_flow_load_balancer_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_l4_flow_load_balancer_top;
    import l4lb_pkg::*;

    logic clk = 0, rst_n = 0;
    logic cfg_valid = 0, cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 0, in_ready;
    logic [10:0] captured_bytes = '0;
    logic [15:0] ether_type = '0;
    logic [7:0] ip_protocol = '0;
    logic [31:0] source_addr = '0, dest_addr = '0, random_value = '0;
    logic [15:0] source_port = '0, dest_port = '0, old_checksum = '0;
    logic out_valid, out_ready = 0;
    logic [1:0] action;
    logic [31:0] new_source_addr, new_dest_addr;
    logic [7:0] new_dest_mac_last, new_source_mac_last;
    logic [15:0] new_checksum;
    logic flow_created, table_full;
    logic [63:0] new_flow_total, forwarded_total;
    int errors, pending;
    logic long_hold = 0;

    // Shadow registers used to shape client and reply frames.
    logic [23:0] cur_prefix = 24'd11276544;
    logic [7:0] cur_client = 8'd6;
    logic [15:0] cur_port = 16'd80;
    logic [31:0] dst_pool[8];
    logic [15:0] sport_pool[8];

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    l4_flow_load_balancer_top dut (.*);

    lb_checker chk (.*);

    // Receiver stall pattern, with an occasional long hold-off.
    always @(negedge clk)
    begin
        if (long_hold) out_ready <= 0;
        else
            case ($urandom_range(0, 3))
                0: out_ready <= 1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= 1;
            endcase
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 0;
        if (idx == REG_SUBNET) cur_prefix = val[23:0];
        if (idx == REG_CLIENT) cur_client = val[7:0];
        if (idx == REG_PORT) cur_port = val[15:0];
    endtask

    // Wait until every request has its result and the block has settled.
    task automatic drain();
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic send_frame(input logic [10:0] cap, input logic [15:0] et,
        input logic [7:0] pr, input logic [31:0] sa, input logic [31:0] da,
        input logic [15:0] sp, input logic [15:0] dp, input logic [15:0] hc,
        input logic [31:0] rv);
        in_valid <= 1;
        captured_bytes <= cap;
        ether_type <= et;
        ip_protocol <= pr;
        source_addr <= sa;
        dest_addr <= da;
        source_port <= sp;
        dest_port <= dp;
        old_checksum <= hc;
        random_value <= rv;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Random frame: mostly well-formed client or reply frames, some noise.
    task automatic random_frame();
        int kind;
        logic [31:0] ca, sa, da;
        logic [15:0] sp, dp;
        kind = $urandom_range(0, 9);
        ca = {cur_prefix, cur_client};
        sa = $urandom;
        da = dst_pool[$urandom_range(0, 7)];
        sp = sport_pool[$urandom_range(0, 7)];
        dp = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'd80;
        if (kind < 5) sa = ca;
        else if (kind < 7) sp = cur_port;
        if (kind == 9)
            send_frame(11'($urandom), $urandom_range(0, 1) ? 16'h0800 : 16'($urandom),
                $urandom_range(0, 1) ? 8'd6 : 8'($urandom), $urandom_range(0, 1) ? ca : sa,
                $urandom, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        else
            send_frame($urandom_range(0, 7) == 0 ? 11'($urandom_range(0, 60)) : 11'd1514,
                16'h0800, 8'd6, sa, da, sp, dp, 16'($urandom), $urandom);
    endtask

    task automatic random_phase(input int count);
        int sent, burst, gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                random_frame();
                sent++;
            end
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_valid <= 0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 0;
    endtask

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < 8; i++) begin
            dst_pool[i] = $urandom;
            sport_pool[i] = 16'($urandom);
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: every abort and pass case, default backend, replies.
        send_frame(11'd0, 16'h0800, 8'd6, 32'hAC0C0606, '0, 16'd1, 16'd2, 16'd3, '0);
        send_frame(11'd13, 16'h0800, 8'd6, '0, '0, '0, '0, '0, '0);
        send_frame(11'd14, 16'h86DD, 8'd6, '0, '0, '0, '0, '0, '0);
        send_frame(11'd33, 16'h0800, 8'd6, '0, '0, '0, '0, '0, '0);
        send_frame(11'd34, 16'h0800, 8'd17, '0, '0, '0, '0, '0, '0);
        send_frame(11'd53, 16'h0800, 8'd6, '0, '0, '0, '0, '0, '0);
        send_frame(11'd2047, 16'hFFFF, 8'hFF, '1, '1, '1, '1, '1, '1);
        send_frame(11'd54, 16'h0800, 8'd6, {cur_prefix, cur_client}, 32'h01020304,
            16'd1000, 16'd80, 16'h1234, '0);
        send_frame(11'd60, 16'h0800, 8'd6, 32'h01020304, 32'hFFFFFFFF,
            16'd80, 16'd1000, 16'hFFFF, '1);
        send_frame(11'd60, 16'h0800, 8'd6, 32'h01020304, '0, 16'd81, '0, '0, '0);
        in_valid <= 0;
        drain();

        // All backends valid, then track, fill the table to overflow.
        write_reg(REG_MASK, 32'h1FFFFFF);
        for (int i = 0; i < 70; i++)
            send_frame(11'd100, 16'h0800, 8'd6, {cur_prefix, cur_client}, 32'(i),
                16'd5, 16'd80, 16'($urandom), $urandom);
        send_frame(11'd100, 16'h0800, 8'd6, {cur_prefix, cur_client}, 32'd3,
            16'd5, 16'd80, '0, '0);
        in_valid <= 0;
        drain();

        // Long receiver hold-off while the sender keeps offering.
        fork
            begin
                long_hold = 1;
                repeat (300) @(posedge clk);
                long_hold = 0;
            end
            random_phase(20);
        join
        drain();

        // Load a fresh configuration with extreme values, then run random traffic.
        write_reg(REG_SUBNET, 32'hFFFFFF);
        write_reg(REG_CLIENT, 32'hFF);
        write_reg(REG_BALANCER, 32'h00);
        write_reg(REG_BMAC, 32'hFF);
        write_reg(REG_DEFAULT, 32'hFF);
        write_reg(REG_MASK, 32'h1000001);
        write_reg(REG_PORT, 32'hFFFF);
        random_phase(200);
        drain();

        write_reg(REG_SUBNET, 32'h0);
        write_reg(REG_CLIENT, 32'h0);
        write_reg(REG_BALANCER, 32'hFF);
        write_reg(REG_BMAC, 32'h00);
        write_reg(REG_DEFAULT, 32'h00);
        write_reg(REG_MASK, 32'h0);
        write_reg(REG_PORT, 32'h0);
        random_phase(200);
        drain();

        for (int p = 0; p < 3; p++) begin
            write_reg(REG_SUBNET, $urandom);
            write_reg(REG_CLIENT, $urandom);
            write_reg(REG_BALANCER, $urandom);
            write_reg(REG_BMAC, $urandom);
            write_reg(REG_DEFAULT, $urandom);
            write_reg(REG_MASK, $urandom);
            write_reg(REG_PORT, $urandom_range(0, 1) ? 32'd80 : $urandom);
            random_phase(140);
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
